[rtl/iibff_pkg.sv]
// Shared types and constants for the indexed image background flood fill block.
package iibff_pkg;

    // Command opcodes carried by an input item.
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Result kinds carried by an output item.
    localparam logic RES_READ     = 1'b0;
    localparam logic RES_RUN_DONE = 1'b1;

    // Color used to mark a pixel that has been queued by the flood.
    localparam logic [7:0] COLOR_VISITED = 8'd255;
    localparam logic [7:0] COLOR_NONE    = 8'd0;

    // Configuration register map; the register index is byte address bit 2.
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned DIM_W      = 10;
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0] DIM_RESET = 10'd64;

    // One command item.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [17:0] pixel_index;
        logic [7:0]  pixel_value;
    } cmd_item_t;

    // One result item.
    typedef struct packed {
        logic       result_kind;
        logic [7:0] read_value;
    } res_item_t;

endpackage

[rtl/indexed_image_background_flood_fill.sv]
// Indexed image store with a queue-based 4-connected background flood fill.
//
// Commands arrive on the cmd channel (valid/ready) and results leave on the
// res channel (valid/ready). A load item writes one pixel and gives no result.
// A read item gives one result with the pixel color; loads and reads are taken
// one per cycle unless the receiver stalls, and a read result passes through
// the memory read register and the output register before it is offered. A
// run item floods the image from pixel (0,0) and gives one result when the
// flood is over; nothing is queued when the fill color is 0 or 255. Only a
// neighbor inside the image is read; the single read port of the image memory,
// with registered read data, sees each neighbor in turn. No command is taken
// during a run. Width and height are written over the APB port; the user must
// write them only while the block is idle, which the block itself does not enforce.
// Reset clears the control state and sets width and height to 64; the image
// and the coordinate ring are undefined until written. When the receiver
// stalls, a finished read waits in the memory read register and the output
// register, and command intake stops only when both are occupied.
module indexed_image_background_flood_fill
    import iibff_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int RING_DEPTH = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_item_t             cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_item_t             res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int DXW = XW + 1;
    localparam int DYW = YW + 1;
    localparam int EW  = XW + YW;
    localparam int PW  = XW + YW + 1;
    localparam int RW  = $clog2(RING_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN_START,
        ST_RUN_FILL,
        ST_RING_RD,
        ST_BASE,
        ST_NB_ISSUE,
        ST_NB_CHECK,
        ST_WRITE_BACK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        NB_LEFT,
        NB_RIGHT,
        NB_UP,
        NB_DOWN
    } nb_dir_t;

    // Memories and their registered read data.
    logic [7:0]    image_mem [STORE_DEPTH];
    logic [EW-1:0] ring_mem  [RING_DEPTH];
    logic [7:0]    img_rdata_reg;
    logic [EW-1:0] ring_rdata_reg;

    // Memory port controls.
    logic          img_we;
    logic [AW-1:0] img_waddr;
    logic [7:0]    img_wdata;
    logic          img_re;
    logic [AW-1:0] img_raddr;
    logic          ring_we;
    logic [EW-1:0] ring_wdata;
    logic          ring_re;

    // Control registers.
    state_t           state_reg, state_next;
    nb_dir_t          nb_reg, nb_next;
    logic [RW-1:0]    wr_idx_reg, wr_idx_next;
    logic [RW-1:0]    rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    logic             pend_zero_reg, pend_zero_next;
    logic             res_valid_reg, res_valid_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;

    // Payload registers.
    res_item_t     res_reg, res_next;
    logic [7:0]    fill_reg, fill_next;
    logic [7:0]    cand_reg, cand_next;
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [AW-1:0] base_reg, base_next;

    logic           out_free;
    logic           out_move;
    logic           cmd_fire;
    logic           cmd_in_range;
    logic [AW-1:0]  cmd_addr;
    logic [DXW-1:0] w_eff;
    logic [DYW-1:0] h_eff;
    logic [PW-1:0]  base_full;
    logic           nb_ok;
    logic [XW-1:0]  nb_x;
    logic [YW-1:0]  nb_y;
    logic [AW-1:0]  nb_addr;
    logic           cfg_write;

    // Next ring index, wrapping at the ring depth.
    function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] idx);
        logic [RW-1:0] r;
        if (idx == RW'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = idx + RW'(1);
        end
        return r;
    endfunction

    // Image dimensions saturated into the supported range.
    always_comb
    begin
        if (width_reg == '0) begin
            w_eff = DXW'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = DXW'(MAX_WIDTH);
        end else begin
            w_eff = DXW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = DYW'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = DYW'(MAX_HEIGHT);
        end else begin
            h_eff = DYW'(height_reg);
        end
    end

    // Linear address of the dequeued pixel.
    assign base_full = PW'(w_eff) * PW'(ring_rdata_reg[EW-1:XW]) + PW'(ring_rdata_reg[XW-1:0]);

    // Neighbor under inspection: bounds check, coordinates and address.
    always_comb
    begin
        nb_x    = x_reg;
        nb_y    = y_reg;
        nb_addr = base_reg;
        nb_ok   = 1'b0;
        case (nb_reg)
            NB_LEFT:
            begin
                nb_ok   = (x_reg != '0);
                nb_x    = x_reg - XW'(1);
                nb_addr = base_reg - AW'(1);
            end
            NB_RIGHT:
            begin
                nb_ok   = (DXW'(x_reg) + DXW'(1)) < w_eff;
                nb_x    = x_reg + XW'(1);
                nb_addr = base_reg + AW'(1);
            end
            NB_UP:
            begin
                nb_ok   = (y_reg != '0);
                nb_y    = y_reg - YW'(1);
                nb_addr = base_reg - AW'(w_eff);
            end
            NB_DOWN:
            begin
                nb_ok   = (DYW'(y_reg) + DYW'(1)) < h_eff;
                nb_y    = y_reg + YW'(1);
                nb_addr = base_reg + AW'(w_eff);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // Handshake terms: a pending read moves into a free output register.
    assign out_free     = !res_valid_reg || res_ready;
    assign out_move     = pend_reg && out_free;
    assign cmd_ready    = (state_reg == ST_IDLE) && (!pend_reg || out_move);
    assign cmd_fire     = cmd_valid && cmd_ready;
    assign cmd_in_range = 32'(cmd.pixel_index) < 32'(STORE_DEPTH);
    assign cmd_addr     = AW'(cmd.pixel_index);
    assign cfg_write    = psel && penable && pwrite && pready;

    // Sequencer, memory port selection and output register control.
    always_comb
    begin
        state_next     = state_reg;
        nb_next        = nb_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_zero_next = pend_zero_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        fill_next      = fill_reg;
        cand_next      = cand_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        base_next      = base_reg;
        img_we         = 1'b0;
        img_waddr      = nb_addr;
        img_wdata      = COLOR_VISITED;
        img_re         = 1'b0;
        img_raddr      = nb_addr;
        ring_we        = 1'b0;
        ring_wdata     = {nb_y, nb_x};
        ring_re        = 1'b0;

        // Output register: a read result first, else a run completion.
        if (out_move) begin
            res_valid_next       = 1'b1;
            res_next.result_kind = RES_READ;
            res_next.read_value  = pend_zero_reg ? COLOR_NONE : img_rdata_reg;
            pend_next            = 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            res_valid_next       = 1'b1;
            res_next.result_kind = RES_RUN_DONE;
            res_next.read_value  = COLOR_NONE;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end

        // Configuration writes.
        if (cfg_write) begin
            case (paddr[2])
                CFG_IDX_WIDTH:  width_next  = pwdata[DIM_W-1:0];
                CFG_IDX_HEIGHT: height_next = pwdata[DIM_W-1:0];
                default:        width_next  = width_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire) begin
                    case (cmd.opcode)
                        OP_LOAD:
                        begin
                            img_we    = cmd_in_range;
                            img_waddr = cmd_addr;
                            img_wdata = cmd.pixel_value;
                        end
                        OP_READ:
                        begin
                            img_re         = cmd_in_range;
                            img_raddr      = cmd_addr;
                            pend_next      = 1'b1;
                            pend_zero_next = !cmd_in_range;
                        end
                        OP_RUN:
                        begin
                            state_next = ST_RUN_START;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN_START:
            begin
                // Wait until an earlier read has left the memory read register.
                if (!pend_reg) begin
                    img_re      = 1'b1;
                    img_raddr   = '0;
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                    state_next  = ST_RUN_FILL;
                end
            end
            ST_RUN_FILL:
            begin
                fill_next = img_rdata_reg;
                if ((img_rdata_reg == COLOR_NONE) || (img_rdata_reg == COLOR_VISITED)) begin
                    state_next = ST_DONE;
                end else begin
                    ring_we     = 1'b1;
                    ring_wdata  = '0;
                    wr_idx_next = ring_inc(wr_idx_reg);
                    state_next  = ST_RING_RD;
                end
            end
            ST_RING_RD:
            begin
                ring_re     = 1'b1;
                rd_idx_next = ring_inc(rd_idx_reg);
                state_next  = ST_BASE;
            end
            ST_BASE:
            begin
                x_next     = ring_rdata_reg[XW-1:0];
                y_next     = ring_rdata_reg[EW-1:XW];
                base_next  = base_full[AW-1:0];
                cand_next  = COLOR_NONE;
                nb_next    = NB_LEFT;
                state_next = ST_NB_ISSUE;
            end
            ST_NB_ISSUE:
            begin
                if (nb_ok) begin
                    img_re     = 1'b1;
                    state_next = ST_NB_CHECK;
                end else if (nb_reg == NB_DOWN) begin
                    state_next = ST_WRITE_BACK;
                end else begin
                    nb_next = nb_dir_t'(nb_reg + 2'd1);
                end
            end
            ST_NB_CHECK:
            begin
                // A background neighbor is marked and queued; others vote.
                if (img_rdata_reg == fill_reg) begin
                    img_we      = 1'b1;
                    ring_we     = 1'b1;
                    wr_idx_next = ring_inc(wr_idx_reg);
                end else if (img_rdata_reg != COLOR_VISITED) begin
                    cand_next = img_rdata_reg;
                end
                if (nb_reg == NB_DOWN) begin
                    state_next = ST_WRITE_BACK;
                end else begin
                    nb_next    = nb_dir_t'(nb_reg + 2'd1);
                    state_next = ST_NB_ISSUE;
                end
            end
            ST_WRITE_BACK:
            begin
                img_we    = 1'b1;
                img_waddr = base_reg;
                img_wdata = cand_reg;
                if (rd_idx_reg != wr_idx_reg) begin
                    state_next = ST_RING_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            nb_reg        <= NB_LEFT;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_zero_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            width_reg     <= DIM_RESET;
            height_reg    <= DIM_RESET;
        end else begin
            state_reg     <= state_next;
            nb_reg        <= nb_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            pend_zero_reg <= pend_zero_next;
            res_valid_reg <= res_valid_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    // Payload registers of the sequencer and the output.
    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        fill_reg <= fill_next;
        cand_reg <= cand_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        base_reg <= base_next;
    end

    // Image memory: one write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (img_we) begin
            image_mem[img_waddr] <= img_wdata;
        end
        if (img_re) begin
            img_rdata_reg <= image_mem[img_raddr];
        end
    end

    // Coordinate ring: written at the write index, read at the read index.
    always_ff @(posedge clk)
    begin
        if (ring_we) begin
            ring_mem[wr_idx_reg] <= ring_wdata;
        end
        if (ring_re) begin
            ring_rdata_reg <= ring_mem[rd_idx_reg];
        end
    end

    // Outputs and configuration read back.
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == CFG_IDX_HEIGHT) ? APB_DATA_W'(height_reg)
                                                    : APB_DATA_W'(width_reg);

`ifndef SYNTHESIS
    // The image memory is never written and read at one address in a cycle.
    a_img_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (img_we && img_re) |-> (img_waddr != img_raddr))
        else $error("image memory read and write collide");

    // The ring is never written and read in the same cycle.
    a_ring_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        ring_we |-> !ring_re)
        else $error("ring read and write in one cycle");

    // A run completion never overtakes a read result.
    a_done_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !pend_reg)
        else $error("run finished with a read still pending");

    // A waiting read result is not overwritten before it moves out.
    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !out_move) |=> (pend_reg && $stable(img_rdata_reg)
                                     && $stable(pend_zero_reg)))
        else $error("pending read data lost");
`endif

endmodule
